// File: hdl/mphc_pkg.sv
package mphc_pkg;

    localparam int NumBuckets     = 16;
    localparam int SlotsPerBucket = 512;
    localparam int BucketW        = $clog2(NumBuckets);
    localparam int SlotW          = $clog2(SlotsPerBucket);
    localparam int AddrW          = BucketW + SlotW;
    localparam int CountW         = SlotW + 1;
    localparam int TotalW         = 14;
    // A new key is refused when (count + 1) * 10 >= slots * 7.
    localparam int FullLimit      = SlotsPerBucket * 7;

    localparam logic [1:0] StatusOk   = 2'd0;
    localparam logic [1:0] StatusWild = 2'd1;
    localparam logic [1:0] StatusFull = 2'd2;

    localparam logic CmdInsert = 1'b0;
    localparam logic CmdLookup = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] value;
        logic [31:0] mask;
        logic [31:0] app_id;
        logic [7:0]  tier;
        logic [7:0]  confidence;
        logic [7:0]  grant_level;
        logic [15:0] payload_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] match_app_id;
        logic [7:0]  match_tier;
        logic [7:0]  match_confidence;
        logic [7:0]  match_grant_level;
        logic [1:0]  match_wildcards;
        logic [TotalW-1:0] entry_total;
    } out_item_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;         // capture the input item
        logic setup_insert; // select insert bucket, activate it
        logic set_bucket;   // clear bucket counter to start lookup scan
        logic next_bucket;  // advance lookup bucket counter
        logic hash_s1;      // hash pipeline steps
        logic hash_s2;
        logic hash_s3;
        logic hash_s4;
        logic rd;           // issue slot read
        logic advance;      // step probe index
        logic write_new;    // write new slot
        logic write_upd;    // overwrite record of existing slot
        logic take_match;   // record lookup match
        logic mark_wild;    // refuse an all-wildcard insert
        logic mark_full;    // refuse a new key in a full bucket
        logic done;         // present result
    } ctl_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_lookup;
        logic wild_refuse;
        logic short_len;
        logic bucket_ok;     // current lookup bucket worth probing
        logic last_bucket;
        logic slot_empty;
        logic slot_hit;
        logic probe_end;     // probe visited every slot
        logic bucket_full;
        logic conf_higher;
    } sts_t;

    function automatic logic [3:0] wild_index(input logic [31:0] m);
        logic [3:0] idx;
        idx = 4'd0;
        for (int i = 0; i < 4; i++) begin
            idx[i] = (m[31-8*i -: 8] == 8'd0);
        end
        return idx;
    endfunction

    function automatic logic [1:0] popcount4(input logic [3:0] v);
        return 2'({1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]} + {1'b0, v[3]});
    endfunction

endpackage

// File: hdl/mphc_ctrl.sv
module mphc_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  mphc_pkg::sts_t sts,
    output mphc_pkg::ctl_t ctl
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_DEC    = 12'b000000000010,
        ST_SCAN   = 12'b000000000100,
        ST_H1     = 12'b000000001000,
        ST_H2     = 12'b000000010000,
        ST_H3     = 12'b000000100000,
        ST_H4     = 12'b000001000000,
        ST_RD     = 12'b000010000000,
        ST_CHK    = 12'b000100000000,
        ST_NEXTB  = 12'b001000000000,
        ST_DONE   = 12'b010000000000,
        ST_WAIT   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                if (sts.is_lookup)
                begin
                    ctl.set_bucket = 1'b1;
                    state_next = sts.short_len ? ST_DONE : ST_SCAN;
                end
                else if (sts.wild_refuse)
                begin
                    ctl.mark_wild = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.setup_insert = 1'b1;
                    state_next = ST_H1;
                end
            end
            ST_SCAN:
            begin
                if (sts.bucket_ok)
                begin
                    state_next = ST_H1;
                end
                else
                begin
                    state_next = ST_NEXTB;
                end
            end
            ST_H1:
            begin
                ctl.hash_s1 = 1'b1;
                state_next = ST_H2;
            end
            ST_H2:
            begin
                ctl.hash_s2 = 1'b1;
                state_next = ST_H3;
            end
            ST_H3:
            begin
                ctl.hash_s3 = 1'b1;
                state_next = ST_H4;
            end
            ST_H4:
            begin
                ctl.hash_s4 = 1'b1;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                ctl.rd = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (sts.slot_hit)
                begin
                    if (sts.is_lookup)
                    begin
                        ctl.take_match = 1'b1;
                        state_next = ST_NEXTB;
                    end
                    else
                    begin
                        ctl.write_upd = sts.conf_higher;
                        state_next = ST_DONE;
                    end
                end
                else if (sts.slot_empty || sts.probe_end)
                begin
                    if (sts.is_lookup)
                    begin
                        state_next = ST_NEXTB;
                    end
                    else
                    begin
                        ctl.write_new = sts.slot_empty && !sts.bucket_full;
                        ctl.mark_full = !(sts.slot_empty && !sts.bucket_full);
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    ctl.advance = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_NEXTB:
            begin
                if (sts.last_bucket)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.next_bucket = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_DONE:
            begin
                ctl.done = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/mphc_datapath.sv
module mphc_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mphc_pkg::in_item_t   in_item,
    input  mphc_pkg::ctl_t       ctl,
    output mphc_pkg::sts_t       sts,
    output logic                 result_valid,
    output mphc_pkg::out_item_t  result
);

    localparam int Nb = mphc_pkg::NumBuckets;
    localparam int Ns = mphc_pkg::SlotsPerBucket;
    localparam int Bw = mphc_pkg::BucketW;
    localparam int Sw = mphc_pkg::SlotW;
    localparam int Aw = mphc_pkg::AddrW;
    localparam int Cw = mphc_pkg::CountW;
    localparam int Tw = mphc_pkg::TotalW;

    // Slot storage; the used bits live in a separate memory cleared after reset.
    logic [31:0] key_mem  [Ns*Nb];
    logic [31:0] app_mem  [Ns*Nb];
    logic [23:0] attr_mem [Ns*Nb];
    logic        used_mem [Ns*Nb];

    logic [Nb-1:0]  active_reg;
    logic [31:0]    bmask_reg [Nb];
    logic [Cw-1:0]  count_reg [Nb];
    logic [Tw-1:0]  total_reg;

    mphc_pkg::in_item_t item_reg;
    logic [Bw-1:0]  bkt_reg;
    logic [31:0]    key_reg;
    logic [31:0]    h_reg;
    logic [Sw-1:0]  idx_reg;
    logic [Sw:0]    visits_reg;
    logic [31:0]    rd_key_reg;
    logic [31:0]    rd_app_reg;
    logic [23:0]    rd_attr_reg;
    logic           rd_used_reg;
    logic           found_reg;
    logic [1:0]     best_reg;
    logic [31:0]    m_app_reg;
    logic [23:0]    m_attr_reg;
    logic [1:0]     m_wild_reg;
    logic [1:0]     status_reg;
    logic           result_valid_reg;
    mphc_pkg::out_item_t result_item;
    logic [Aw:0]    clr_reg;

    logic [Bw-1:0]  ins_bkt;
    logic [31:0]    cur_mask;
    logic [Aw-1:0]  addr;
    logic [1:0]     cur_wild;
    logic [Cw+3:0]  full_lhs;

    assign ins_bkt  = Bw'(mphc_pkg::wild_index(item_reg.mask));
    assign cur_mask = bmask_reg[bkt_reg];
    assign addr     = {bkt_reg, idx_reg};
    assign cur_wild = mphc_pkg::popcount4(4'(bkt_reg));
    assign full_lhs = ((Cw+4)'(count_reg[bkt_reg]) + 1'b1) * (Cw+4)'(10);

    always_comb
    begin
        sts.is_lookup   = (item_reg.command == mphc_pkg::CmdLookup);
        sts.wild_refuse = (item_reg.mask == 32'd0);
        sts.short_len   = (item_reg.payload_length < 16'd4);
        sts.bucket_ok   = active_reg[bkt_reg] && (count_reg[bkt_reg] != '0)
                          && !(found_reg && cur_wild >= best_reg);
        sts.last_bucket = (bkt_reg == Bw'(Nb - 1));
        sts.slot_empty  = !rd_used_reg;
        sts.slot_hit    = rd_used_reg && (rd_key_reg == key_reg);
        sts.probe_end   = (visits_reg == (Sw+1)'(Ns));
        sts.bucket_full = (32'(full_lhs) >= 32'(mphc_pkg::FullLimit));
        sts.conf_higher = (item_reg.confidence > rd_attr_reg[15:8]);
    end

    // Memory ports: one read and one write per cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.rd)
        begin
            rd_key_reg  <= key_mem[addr];
            rd_app_reg  <= app_mem[addr];
            rd_attr_reg <= attr_mem[addr];
        end
        if (ctl.write_new)
        begin
            key_mem[addr] <= key_reg;
        end
        if (ctl.write_new || ctl.write_upd)
        begin
            app_mem[addr]  <= item_reg.app_id;
            attr_mem[addr] <= {item_reg.grant_level, item_reg.confidence, item_reg.tier};
        end
    end

    always_ff @(posedge clk)
    begin
        if (!clr_reg[Aw])
        begin
            used_mem[clr_reg[Aw-1:0]] <= 1'b0;
        end
        else if (ctl.write_new)
        begin
            used_mem[addr] <= 1'b1;
        end
        if (ctl.rd)
        begin
            rd_used_reg <= used_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (!clr_reg[Aw])
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            item_reg <= in_item;
        end
        if (ctl.setup_insert)
        begin
            bkt_reg <= ins_bkt;
        end
        if (ctl.set_bucket)
        begin
            bkt_reg <= '0;
        end
        if (ctl.next_bucket)
        begin
            bkt_reg <= bkt_reg + 1'b1;
        end
        if (ctl.setup_insert && !active_reg[ins_bkt])
        begin
            bmask_reg[ins_bkt] <= item_reg.mask;
        end
        // Hash: xorshift, multiply, xorshift with multiply, and a final xorshift, each registered.
        if (ctl.hash_s1)
        begin
            key_reg <= item_reg.value & cur_mask;
            h_reg   <= (item_reg.value & cur_mask)
                       ^ ((item_reg.value & cur_mask) >> 16);
        end
        if (ctl.hash_s2)
        begin
            h_reg <= h_reg * 32'h7feb352d;
        end
        if (ctl.hash_s3)
        begin
            h_reg <= (h_reg ^ (h_reg >> 15)) * 32'h846ca68b;
        end
        if (ctl.hash_s4)
        begin
            idx_reg    <= Sw'(h_reg ^ (h_reg >> 16));
            visits_reg <= '0;
        end
        if (ctl.rd)
        begin
            visits_reg <= visits_reg + 1'b1;
        end
        if (ctl.advance)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (ctl.take_match)
        begin
            m_app_reg  <= rd_app_reg;
            m_attr_reg <= rd_attr_reg;
            m_wild_reg <= cur_wild;
            best_reg   <= cur_wild;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= '0;
            total_reg        <= '0;
            found_reg        <= 1'b0;
            status_reg       <= mphc_pkg::StatusOk;
            result_valid_reg <= 1'b0;
            for (int b = 0; b < Nb; b++)
            begin
                count_reg[b] <= '0;
            end
        end
        else
        begin
            result_valid_reg <= ctl.done;
            if (ctl.load)
            begin
                found_reg  <= 1'b0;
                status_reg <= mphc_pkg::StatusOk;
            end
            else if (ctl.mark_wild)
            begin
                status_reg <= mphc_pkg::StatusWild;
            end
            else if (ctl.mark_full)
            begin
                status_reg <= mphc_pkg::StatusFull;
            end
            if (ctl.setup_insert)
            begin
                active_reg[ins_bkt] <= 1'b1;
            end
            if (ctl.take_match)
            begin
                found_reg <= 1'b1;
            end
            if (ctl.write_new)
            begin
                count_reg[bkt_reg] <= count_reg[bkt_reg] + 1'b1;
                total_reg <= total_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        result_item.status            = status_reg;
        result_item.found             = found_reg;
        result_item.match_app_id      = found_reg ? m_app_reg : 32'd0;
        result_item.match_tier        = found_reg ? m_attr_reg[7:0] : 8'd0;
        result_item.match_confidence  = found_reg ? m_attr_reg[15:8] : 8'd0;
        result_item.match_grant_level = found_reg ? m_attr_reg[23:16] : 8'd0;
        result_item.match_wildcards   = found_reg ? m_wild_reg : 2'd0;
        result_item.entry_total       = total_reg;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_item;

endmodule

// File: hdl/masked_pattern_hash_classifier.sv
// Channel | Signals              | Transfer
// input   | start, busy, in_item | start high and busy low at a rising edge
// result  | done, out_item       | done high for one cycle; always taken
//
// An insert hashes its key, then reads and checks one slot at a time; each extra
// probed slot repeats the read and check, since the slot memory has a single read
// port. The input is freed in the cycle after the result strobe. A refused insert
// or a short lookup skips the hash and probe. Any other lookup walks all 16 buckets,
// skipping inactive or empty ones and, after a match, ones with no fewer wildcards.
// After reset a clearing pass over all 8192 slots runs with busy high; no stalls.
module masked_pattern_hash_classifier
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mphc_pkg::in_item_t  in_item,
    output logic                done,
    output mphc_pkg::out_item_t out_item
);

    mphc_pkg::ctl_t ctl;
    mphc_pkg::sts_t sts;
    logic           ctrl_busy;
    logic [mphc_pkg::AddrW:0] clr_cnt_reg;
    logic           clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (!clr_cnt_reg[mphc_pkg::AddrW])
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign clearing = !clr_cnt_reg[mphc_pkg::AddrW];
    assign busy     = ctrl_busy || clearing;

    mphc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start && !clearing),
        .busy  (ctrl_busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    mphc_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_item      (in_item),
        .ctl          (ctl),
        .sts          (sts),
        .result_valid (done),
        .result       (out_item)
    );

    a_no_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.write_new && ctl.write_upd))
        else $error("two slot writes in one cycle");

    a_found_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_item.found) |-> (out_item.status == mphc_pkg::StatusOk))
        else $error("match reported with a refusal status");

endmodule
